// ===== rtl/ptpm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptpm_pkg: shared types and constants for the prefix table pattern matcher
// Item types, cell control bundle and default pattern capacity.
// ----------------------------------------------------------------------------
package ptpm_pkg;

  localparam int unsigned MaxPatternDefault = 64;
  localparam int unsigned SymW              = 8;
  localparam int unsigned StoredLenW        = 7;

  localparam logic OpPattern = 1'b0;
  localparam logic OpText    = 1'b1;

  typedef struct packed {
    logic            op;
    logic [SymW-1:0] symbol;
    logic            last;
  } ptpm_req_t;

  typedef struct packed {
    logic                  match_end;
    logic                  found;
    logic [StoredLenW-1:0] stored_length;
    logic                  overflow;
  } ptpm_rsp_t;

  typedef struct packed {
    logic            text_en;
    logic            act_clr;
    logic            pat_wr;
    logic [SymW-1:0] sym;
  } ptpm_cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ptpm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ptpm_cell: one pattern position of the matcher row
// Holds one pattern byte, a tail mark and a prefix-active flag fed by the
// neighbor below.
// ----------------------------------------------------------------------------
module ptpm_cell
  import ptpm_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ptpm_cell_ctl_t ctl_i,
  input  wire logic           wr_sel_i,
  input  wire logic           prev_active_i,
  output logic                active_o,
  output logic                hit_o
);

  logic [SymW-1:0] byte_q;
  logic            tail_q, tail_d;
  logic            active_q, active_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.pat_wr && wr_sel_i) begin
      byte_q <= ctl_i.sym;
    end
  end

  always_comb begin
    tail_d   = tail_q;
    active_d = active_q;
    if (ctl_i.pat_wr) begin
      tail_d = wr_sel_i;
    end
    if (ctl_i.act_clr) begin
      active_d = 1'b0;
    end else if (ctl_i.text_en) begin
      active_d = prev_active_i && (byte_q == ctl_i.sym);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      tail_q   <= tail_d;
      active_q <= active_d;
    end
  end

  assign active_o = active_q;
  assign hit_o    = active_q && tail_q;

endmodule
`default_nettype wire

// ===== rtl/prefix_table_pattern_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_table_pattern_matcher: streaming pattern search over a cell row
// Pattern bytes load into a row of cells; text bytes advance per-cell
// prefix-active flags, and a flag at the pattern tail marks an occurrence.
// ----------------------------------------------------------------------------
// For each item, the cell row updates at the accepting edge,
// the hit flags of the row are combined and registered at the next edge,
// and the result strobe is high for the cycle after that. busy is high for
// the one cycle in between, so a new item can be accepted at the same edge
// that takes the previous result. The receiver cannot stall; every result
// must be taken in its strobe cycle. Overlapping occurrences are all
// reported, and pattern bytes beyond MaxPattern are dropped and flagged.
// ----------------------------------------------------------------------------
module prefix_table_pattern_matcher
  import ptpm_pkg::*;
#(
  parameter int unsigned MaxPattern = MaxPatternDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  input  wire ptpm_req_t req_i,
  output logic           busy,
  output logic           res_valid_o,
  output ptpm_rsp_t      res_o
);

  localparam int unsigned IdxW = $clog2(MaxPattern);
  localparam int unsigned LenW = $clog2(MaxPattern + 1);

  localparam logic StIdle   = 1'b0;
  localparam logic StReport = 1'b1;

  logic            state_q, state_d;
  logic            op_q, last_q, ovf_q;
  logic [LenW-1:0] length_q, length_d;
  logic            closed_q, closed_d;
  logic            found_q, found_d;
  logic            res_valid_q, res_valid_d;
  ptpm_rsp_t       res_q, res_d;
  logic            ovf_d;

  logic            accept;
  logic [LenW-1:0] len_base;
  logic            full;
  logic [IdxW-1:0] wr_idx;
  logic            match;
  logic            found_new;

  ptpm_cell_ctl_t        ctl;
  logic [MaxPattern-1:0] wr_sel;
  logic [MaxPattern-1:0] active;
  logic [MaxPattern-1:0] hit;

  assign accept   = start && (state_q == StIdle);
  assign len_base = closed_q ? '0 : length_q;
  assign full     = (len_base == LenW'(MaxPattern));
  assign wr_idx   = len_base[IdxW-1:0];
  assign match    = (op_q == OpText) && (|hit);
  assign found_new = found_q || match;

  always_comb begin
    ctl.sym     = req_i.symbol;
    ctl.pat_wr  = accept && (req_i.op == OpPattern) && !full;
    ctl.text_en = accept && (req_i.op == OpText);
    ctl.act_clr = (accept && (req_i.op == OpPattern) && closed_q) ||
                  ((state_q == StReport) && (op_q == OpText) && last_q);
  end

  for (genvar i = 0; i < MaxPattern; i++) begin : g_cell
    assign wr_sel[i] = (wr_idx == IdxW'(i));
    if (i == 0) begin : g_head
      ptpm_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctl_i         (ctl),
        .wr_sel_i      (wr_sel[i]),
        .prev_active_i (1'b1),
        .active_o      (active[i]),
        .hit_o         (hit[i])
      );
    end else begin : g_body
      ptpm_cell u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .ctl_i         (ctl),
        .wr_sel_i      (wr_sel[i]),
        .prev_active_i (active[i-1]),
        .active_o      (active[i]),
        .hit_o         (hit[i])
      );
    end
  end

  always_comb begin
    state_d     = state_q;
    length_d    = length_q;
    closed_d    = closed_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StReport;
          if (req_i.op == OpPattern) begin
            length_d = full ? len_base : len_base + LenW'(1);
            ovf_d    = full;
            closed_d = req_i.last;
            if (closed_q) begin
              found_d = 1'b0;
            end
          end else begin
            ovf_d    = 1'b0;
            closed_d = 1'b1;
          end
        end
      end
      StReport: begin
        state_d             = StIdle;
        res_valid_d         = 1'b1;
        res_d.match_end     = match;
        res_d.found         = found_new;
        res_d.stored_length = StoredLenW'(length_q);
        res_d.overflow      = ovf_q;
        found_d             = (op_q == OpText && last_q) ? 1'b0 : found_new;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= req_i.op;
      last_q <= req_i.last;
    end
    ovf_q <= ovf_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      length_q    <= '0;
      closed_q    <= 1'b1;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      length_q    <= length_d;
      closed_q    <= closed_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign busy        = (state_q == StReport);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for prefix_table_pattern_matcher
// Runs short directed item sequences (empty pattern, byte extremes, open
// pattern closed by text, overlapping hits, capacity overflow), then random
// pattern/text sessions mixed with noise. An in-bench prefix-table matcher
// predicts every result, and each strobed result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import ptpm_pkg::*;

  localparam int unsigned PatCap = MaxPatternDefault;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      start;
  ptpm_req_t req_i;
  logic      busy;
  logic      res_valid_o;
  ptpm_rsp_t res_o;

  prefix_table_pattern_matcher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [7:0] pat_mem [PatCap];
  logic [5:0] fail_mem[PatCap];
  logic [6:0] pat_len;
  logic       pat_closed;
  logic [6:0] match_pos;
  logic       found_flag;

  ptpm_rsp_t outcome_q[$];
  int        errors     = 0;
  int        n_items    = 0;
  int        n_hits     = 0;
  int        n_dropped  = 0;
  int        n_sessions = 0;
  bit        gaps_on    = 1'b1;

  function automatic ptpm_rsp_t kmp_outcome(ptpm_req_t r);
    int        k;
    ptpm_rsp_t o;
    o = '0;
    if (r.op == OpPattern) begin
      if (pat_closed) begin
        pat_len    = '0;
        match_pos  = '0;
        found_flag = 1'b0;
        pat_closed = 1'b0;
      end
      if (pat_len < PatCap) begin
        pat_mem[pat_len] = r.symbol;
        k = 0;
        if (pat_len > 0) begin
          k = fail_mem[pat_len-1];
          while (k > 0 && pat_mem[k] != r.symbol) k = fail_mem[k-1];
          if (pat_mem[k] == r.symbol) k++;
        end
        fail_mem[pat_len] = 6'(k);
        pat_len = pat_len + 7'd1;
      end else begin
        o.overflow = 1'b1;
      end
      if (r.last) pat_closed = 1'b1;
      o.found = found_flag;
    end else begin
      pat_closed = 1'b1;
      if (pat_len != 0) begin
        k = (match_pos >= pat_len) ? 0 : int'(match_pos);
        while (k > 0 && pat_mem[k] != r.symbol) k = fail_mem[k-1];
        if (pat_mem[k] == r.symbol) k++;
        if (k == pat_len) begin
          match_pos   = 7'(fail_mem[pat_len-1]);
          o.match_end = 1'b1;
          found_flag  = 1'b1;
        end else begin
          match_pos = 7'(k);
        end
      end
      o.found = found_flag;
      if (r.last) begin
        found_flag = 1'b0;
        match_pos  = '0;
      end
    end
    o.stored_length = pat_len;
    return o;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    ptpm_rsp_t exp_r;
    if (rst_ni && res_valid_o) begin
      if (outcome_q.size() == 0) begin
        $error("result with nothing outstanding");
        errors++;
      end else begin
        exp_r = outcome_q.pop_front();
        check_field("match_end", 32'(exp_r.match_end), 32'(res_o.match_end));
        check_field("found", 32'(exp_r.found), 32'(res_o.found));
        check_field("stored_length", 32'(exp_r.stored_length),
                    32'(res_o.stored_length));
        check_field("overflow", 32'(exp_r.overflow), 32'(res_o.overflow));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic idle_cycles(int n);
    if (n > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_item(logic op, logic [7:0] sym, logic last);
    ptpm_req_t r;
    ptpm_rsp_t o;
    r.op     = op;
    r.symbol = sym;
    r.last   = last;
    if (gaps_on) idle_cycles(pick_gap());
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    o = kmp_outcome(r);
    outcome_q = {outcome_q, o};
    n_items++;
    if (o.match_end) n_hits++;
    if (o.overflow) n_dropped++;
  endtask

  task automatic wait_drained();
    idle_cycles(1);
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_pattern();
    send_item(OpText, 8'h00, 1'b0);
    send_item(OpText, 8'hFF, 1'b1);
  endtask

  task automatic test_extreme_symbols();
    send_item(OpPattern, 8'h00, 1'b0);
    send_item(OpPattern, 8'hFF, 1'b1);
    send_item(OpText, 8'h00, 1'b0);
    send_item(OpText, 8'hFF, 1'b0);
    send_item(OpText, 8'h00, 1'b0);
    send_item(OpText, 8'hFF, 1'b1);
  endtask

  task automatic test_open_pattern_overlap();
    send_item(OpPattern, 8'h41, 1'b0);
    send_item(OpPattern, 8'h42, 1'b0);
    send_item(OpPattern, 8'h41, 1'b0);
    send_item(OpText, 8'h41, 1'b0);
    send_item(OpText, 8'h42, 1'b0);
    send_item(OpText, 8'h41, 1'b0);
    send_item(OpText, 8'h42, 1'b0);
    send_item(OpText, 8'h41, 1'b1);
  endtask

  task automatic test_single_byte();
    send_item(OpText, 8'h55, 1'b0);
    send_item(OpPattern, 8'h55, 1'b1);
    send_item(OpText, 8'h55, 1'b0);
    send_item(OpText, 8'h55, 1'b1);
  endtask

  task automatic test_capacity();
    logic [7:0] s;
    int         n;
    n = PatCap + 3;
    for (int i = 0; i < n; i++) begin
      s = (i % 7 == 6) ? 8'hA5 : 8'($urandom_range(0, 255));
      send_item(OpPattern, s, i == n - 1);
    end
    for (int i = 0; i < 8; i++) send_item(OpText, pat_mem[i], i == 7);
  endtask

  task automatic run_session();
    logic [7:0] alpha[3];
    logic [7:0] pat[$];
    logic [7:0] txt[$];
    int         n_alpha;
    int         plen;
    int         n_texts;
    int         tlen;
    n_alpha = $urandom_range(1, 3);
    foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
    plen = ($urandom_range(0, 99) < 3) ? $urandom_range(58, 68) : $urandom_range(1, 6);
    gaps_on = ($urandom_range(0, 3) != 0);
    pat.delete();
    for (int i = 0; i < plen; i++) pat = {pat, alpha[$urandom_range(0, n_alpha - 1)]};
    for (int i = 0; i < plen; i++)
      send_item(OpPattern, pat[i], (i == plen - 1) && ($urandom_range(0, 9) != 0));
    n_texts = $urandom_range(1, 3);
    for (int t = 0; t < n_texts; t++) begin
      tlen = $urandom_range(1, 24);
      txt.delete();
      while (txt.size() < tlen) begin
        if ($urandom_range(0, 99) < 30 && plen <= 8) begin
          foreach (pat[i]) txt = {txt, pat[i]};
        end else begin
          txt = {txt, alpha[$urandom_range(0, n_alpha - 1)]};
        end
      end
      foreach (txt[i])
        send_item(OpText, txt[i], (i == txt.size() - 1) && ($urandom_range(0, 9) != 0));
    end
    n_sessions++;
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(1, 8);
    gaps_on = 1'b1;
    repeat (n)
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_traffic();
    int r;
    while (n_items < 480) begin
      r = $urandom_range(0, 9);
      if (r < 7) run_session();
      else if (r < 9) run_noise();
      else wait_drained();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_pattern();
    test_extreme_symbols();
    test_open_pattern_overlap();
    test_single_byte();
    wait_drained();
    test_capacity();
    wait_drained();
    test_random_traffic();

    idle_cycles(1);
    for (int i = 0; i < 50 && outcome_q.size() != 0; i++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      $error("%0d results never arrived", outcome_q.size());
      errors++;
    end
    $display("summary: %0d items over %0d random sessions", n_items, n_sessions);
    $display("summary: %0d pattern hits, %0d dropped pattern bytes", n_hits, n_dropped);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("tb: failure");
    $finish;
  end

endmodule
